// ===== hdl/rbcs_pkg.sv =====
// Shared types, constants and helpers for the bump-and-turn cleaning sequencer.
package rbcs_pkg;

	// Sizing
	localparam int SPIN_ENTRIES   = 6;
	localparam int IR_SENSORS     = 10;
	localparam int SPIN_IDX_W     = (SPIN_ENTRIES > 1) ? $clog2(SPIN_ENTRIES) : 1;
	localparam int SPIN_TABLE_LEN = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int IN_TDATA_W     = 96;
	localparam int OUT_TDATA_W    = 32;

	// Front IR sensors that lower the cruise ceiling: bits 0, 2, 4, 6, 7
	localparam logic [IR_SENSORS-1:0] IR_NEAR_MASK = IR_SENSORS'(8'hD5);

	// Spin durations in ms
	localparam logic [10:0] SPIN_MS [SPIN_TABLE_LEN] = '{
		11'd500, 11'd800, 11'd1000, 11'd1200, 11'd1500, 11'd2000
	};

	// Commands
	typedef enum logic [1:0] {
		CMD_STEP  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_e;

	// Phases
	typedef enum logic [2:0] {
		PH_CRUISE       = 3'd0,
		PH_REV_SPIN     = 3'd1,
		PH_SPIN         = 3'd2,
		PH_REV_RIGHT    = 3'd3,
		PH_FOLLOW_RIGHT = 3'd4,
		PH_REV_LEFT     = 3'd5,
		PH_FOLLOW_LEFT  = 3'd6
	} phase_e;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REVERSE_PULSES    = 3'd0,
		CFG_EDGE_MIN_MS       = 3'd1,
		CFG_HEADING_TOLERANCE = 3'd2,
		CFG_CRUISE_SPEED      = 3'd3,
		CFG_NEAR_SPEED        = 3'd4,
		CFG_RAMP_STEP         = 3'd5,
		CFG_REVERSE_SPEED     = 3'd6,
		CFG_SPIN_SPEED        = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		logic [15:0] reverse_pulses;
		logic [15:0] edge_min_ms;
		logic [11:0] heading_tolerance;
		logic [7:0]  cruise_speed;
		logic [7:0]  near_speed;
		logic [7:0]  ramp_step;
		logic [7:0]  reverse_speed;
		logic [7:0]  spin_speed;
	} cfg_t;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [1:0]            bump_code;
		logic                  cliff_left;
		logic                  cliff_middle;
		logic                  cliff_right;
		logic [IR_SENSORS-1:0] ir_obstacles;
		logic [31:0]           wheel_pulses;
		logic [31:0]           now_ms;
		logic signed [12:0]    heading;
	} in_item_t;

	typedef struct packed {
		logic              set_speed;
		logic signed [8:0] left_speed;
		logic signed [8:0] right_speed;
		logic              edge_start;
		logic              edge_side;
		logic              edge_stop;
		logic [2:0]        phase;
		logic              running;
	} out_item_t;

	// Spin time for a table position; positions past the table use the last entry
	function automatic logic [10:0] spin_limit(input logic [SPIN_IDX_W-1:0] idx);
		logic [2:0] sel;
		sel = (32'(idx) < SPIN_TABLE_LEN) ? 3'(idx) : 3'(SPIN_TABLE_LEN - 1);
		return SPIN_MS[sel];
	endfunction

endpackage

// ===== hdl/random_bump_cleaning_sequencer.sv =====
// Top level of the bump-and-turn cleaning sequencer: stream ports and staging registers.
//
// Usage:
//   s_* carries one control tick per item; m_* returns exactly one result per tick,
//   in order. cfg_wr_en/cfg_index/cfg_data write the eight settings; write them only
//   while no tick is in flight.
//   An accepted tick is held in an input register; the phase logic evaluates it and,
//   once the result register is empty or being read, loads the result register and
//   the strategy state together.
//   Throughput: one tick per cycle while m_tready is high; the next tick only needs the
//   state that the previous tick left, which the result-register edge already carries.
//   When m_tready is low the result register holds and one more tick waits in the
//   input register; s_tready falls only when both are full.
//   Reset clears the strategy (not running, cruise phase, ramp, marks and spin index
//   zero), empties both registers and loads the default settings.
module random_bump_cleaning_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	// cmd[1:0], bump_code[3:2], cliff_left[4], cliff_middle[5], cliff_right[6],
	// ir_obstacles[16:7], wheel_pulses[48:17], now_ms[80:49], heading[93:81]
	input  logic [rbcs_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// set_speed[0], left_speed[9:1], right_speed[18:10], edge_start[19],
	// edge_side[20], edge_stop[21], phase[24:22], running[25]
	output logic [rbcs_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_wr_en,
	input  logic [rbcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rbcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	rbcs_pkg::in_item_t   item_s1;
	logic                 valid_s1;
	rbcs_pkg::out_item_t  res_q;
	logic                 res_valid_q;
	rbcs_pkg::out_item_t  result;
	rbcs_pkg::cfg_t       cfg;
	rbcs_pkg::in_item_t   in_item;
	logic                 advance;

	// Unpack incoming item
	assign in_item.cmd          = s_tdata[1:0];
	assign in_item.bump_code    = s_tdata[3:2];
	assign in_item.cliff_left   = s_tdata[4];
	assign in_item.cliff_middle = s_tdata[5];
	assign in_item.cliff_right  = s_tdata[6];
	assign in_item.ir_obstacles = s_tdata[16:7];
	assign in_item.wheel_pulses = s_tdata[48:17];
	assign in_item.now_ms       = s_tdata[80:49];
	assign in_item.heading      = s_tdata[93:81];

	// Handshake
	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= in_item;
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= 1'b1;
		else if (m_tready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= result;
	end

	rbcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rbcs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// Pack outgoing item
	assign m_tvalid = res_valid_q;
	assign m_tdata  = {
		6'd0,
		res_q.running,
		res_q.phase,
		res_q.edge_stop,
		res_q.edge_side,
		res_q.edge_start,
		res_q.right_speed,
		res_q.left_speed,
		res_q.set_speed
	};

endmodule

// ===== hdl/rbcs_cfg.sv =====
// Configuration register file for the cleaning sequencer.
module rbcs_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [rbcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rbcs_pkg::cfg_t                   cfg
);

	rbcs_pkg::cfg_t cfg_q;

	// Register writes, reset to defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reverse_pulses    <= 16'd140;
			cfg_q.edge_min_ms       <= 16'd3000;
			cfg_q.heading_tolerance <= 12'd500;
			cfg_q.cruise_speed      <= 8'd180;
			cfg_q.near_speed        <= 8'd120;
			cfg_q.ramp_step         <= 8'd20;
			cfg_q.reverse_speed     <= 8'd120;
			cfg_q.spin_speed        <= 8'd100;
		end else if (cfg_wr_en) begin
			unique case (rbcs_pkg::cfg_idx_e'(cfg_index))
				rbcs_pkg::CFG_REVERSE_PULSES:    cfg_q.reverse_pulses    <= cfg_data;
				rbcs_pkg::CFG_EDGE_MIN_MS:       cfg_q.edge_min_ms       <= cfg_data;
				rbcs_pkg::CFG_HEADING_TOLERANCE: cfg_q.heading_tolerance <= cfg_data[11:0];
				rbcs_pkg::CFG_CRUISE_SPEED:      cfg_q.cruise_speed      <= cfg_data[7:0];
				rbcs_pkg::CFG_NEAR_SPEED:        cfg_q.near_speed        <= cfg_data[7:0];
				rbcs_pkg::CFG_RAMP_STEP:         cfg_q.ramp_step         <= cfg_data[7:0];
				rbcs_pkg::CFG_REVERSE_SPEED:     cfg_q.reverse_speed     <= cfg_data[7:0];
				rbcs_pkg::CFG_SPIN_SPEED:        cfg_q.spin_speed        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/rbcs_core.sv =====
// Phase sequencer: strategy state and per-tick command logic.
module rbcs_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  rbcs_pkg::in_item_t   item,
	input  rbcs_pkg::cfg_t       cfg,
	output rbcs_pkg::out_item_t  result
);

	rbcs_pkg::phase_e                    phase_q, phase_n;
	logic                                active_q, active_n;
	logic [7:0]                          ramp_q, ramp_n;
	logic [31:0]                         mark_pulses_q, mark_pulses_n;
	logic [31:0]                         mark_time_q, mark_time_n;
	logic signed [12:0]                  mark_heading_q, mark_heading_n;
	logic [rbcs_pkg::SPIN_IDX_W-1:0]     spin_idx_q, spin_idx_n;

	logic                                hit, double_hit, ir_near, rev_done;
	logic [7:0]                          ceiling;
	logic [8:0]                          ramp_sum;
	logic [31:0]                         pulse_delta, time_delta;
	logic signed [13:0]                  head_diff;
	logic [12:0]                         head_mag;
	logic signed [8:0]                   ls, rs;
	logic                                set_speed, e_start, e_side, e_stop;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= rbcs_pkg::PH_CRUISE;
			active_q       <= 1'b0;
			ramp_q         <= '0;
			mark_pulses_q  <= '0;
			mark_time_q    <= '0;
			mark_heading_q <= '0;
			spin_idx_q     <= '0;
		end else if (step_en) begin
			phase_q        <= phase_n;
			active_q       <= active_n;
			ramp_q         <= ramp_n;
			mark_pulses_q  <= mark_pulses_n;
			mark_time_q    <= mark_time_n;
			mark_heading_q <= mark_heading_n;
			spin_idx_q     <= spin_idx_n;
		end
	end

	// Shared datapath terms
	assign hit         = (item.bump_code != 2'd0) || item.cliff_left || item.cliff_middle
		|| item.cliff_right;
	assign double_hit  = (item.bump_code == 2'd3) || item.cliff_left || item.cliff_middle
		|| item.cliff_right;
	assign ir_near     = |(item.ir_obstacles & rbcs_pkg::IR_NEAR_MASK);
	assign ceiling     = ir_near ? cfg.near_speed : cfg.cruise_speed;
	assign ramp_sum    = {1'b0, ramp_q} + {1'b0, cfg.ramp_step};
	assign pulse_delta = item.wheel_pulses - mark_pulses_q;
	assign time_delta  = item.now_ms - mark_time_q;
	assign rev_done    = pulse_delta >= {16'd0, cfg.reverse_pulses};
	assign head_diff   = 14'(mark_heading_q) - 14'(item.heading);
	assign head_mag    = head_diff[13] ? 13'(-head_diff) : head_diff[12:0];

	// Next state and commands
	always_comb begin
		phase_n        = phase_q;
		active_n       = active_q;
		ramp_n         = ramp_q;
		mark_pulses_n  = mark_pulses_q;
		mark_time_n    = mark_time_q;
		mark_heading_n = mark_heading_q;
		spin_idx_n     = spin_idx_q;
		set_speed      = 1'b0;
		e_start        = 1'b0;
		e_side         = 1'b0;
		e_stop         = 1'b0;
		ls             = '0;
		rs             = '0;

		if (item.cmd == rbcs_pkg::CMD_START) begin
			active_n    = 1'b1;
			phase_n     = rbcs_pkg::PH_CRUISE;
			mark_time_n = '0;
		end else if (item.cmd == rbcs_pkg::CMD_STOP) begin
			active_n    = 1'b0;
			phase_n     = rbcs_pkg::PH_CRUISE;
			mark_time_n = '0;
			e_stop      = 1'b1;
		end else if (item.cmd == rbcs_pkg::CMD_STEP && active_q) begin
			unique case (phase_q)
				rbcs_pkg::PH_CRUISE: begin
					set_speed = 1'b1;
					if (hit) begin
						ls            = 9'd0 - {1'b0, cfg.reverse_speed};
						rs            = 9'd0 - {1'b0, cfg.reverse_speed};
						mark_pulses_n = item.wheel_pulses;
						ramp_n        = '0;
						if (double_hit)
							phase_n = rbcs_pkg::PH_REV_SPIN;
						else if (item.bump_code == 2'd2)
							phase_n = rbcs_pkg::PH_REV_RIGHT;
						else
							phase_n = rbcs_pkg::PH_REV_LEFT;
					end else begin
						if (ramp_q < ceiling)
							ramp_n = ramp_sum[8] ? 8'hFF : ramp_sum[7:0];
						ls = {1'b0, ramp_n};
						rs = {1'b0, ramp_n};
					end
				end
				rbcs_pkg::PH_REV_SPIN: begin
					if (rev_done) begin
						mark_heading_n = item.heading;
						mark_time_n    = item.now_ms;
						set_speed      = 1'b1;
						// even time spins left wheel backward
						if (!item.now_ms[0]) begin
							ls = 9'd0 - {1'b0, cfg.spin_speed};
							rs = {1'b0, cfg.spin_speed};
						end else begin
							ls = {1'b0, cfg.spin_speed};
							rs = 9'd0 - {1'b0, cfg.spin_speed};
						end
						phase_n = rbcs_pkg::PH_SPIN;
					end
				end
				rbcs_pkg::PH_REV_RIGHT, rbcs_pkg::PH_REV_LEFT: begin
					if (rev_done) begin
						mark_heading_n = item.heading;
						mark_time_n    = item.now_ms;
						e_start        = 1'b1;
						e_side         = (phase_q == rbcs_pkg::PH_REV_LEFT);
						phase_n        = (phase_q == rbcs_pkg::PH_REV_LEFT)
							? rbcs_pkg::PH_FOLLOW_LEFT : rbcs_pkg::PH_FOLLOW_RIGHT;
					end
				end
				rbcs_pkg::PH_SPIN: begin
					spin_idx_n = (spin_idx_q == rbcs_pkg::SPIN_IDX_W'(rbcs_pkg::SPIN_ENTRIES - 1))
						? '0 : spin_idx_q + 1'b1;
					if (time_delta >= 32'(rbcs_pkg::spin_limit(spin_idx_n)))
						phase_n = rbcs_pkg::PH_CRUISE;
				end
				rbcs_pkg::PH_FOLLOW_RIGHT, rbcs_pkg::PH_FOLLOW_LEFT: begin
					if (time_delta >= {16'd0, cfg.edge_min_ms}
						&& head_mag <= {1'b0, cfg.heading_tolerance}) begin
						e_stop  = 1'b1;
						phase_n = rbcs_pkg::PH_CRUISE;
					end
				end
				default: phase_n = rbcs_pkg::PH_CRUISE;
			endcase
		end

		result.set_speed   = set_speed;
		result.left_speed  = ls;
		result.right_speed = rs;
		result.edge_start  = e_start;
		result.edge_side   = e_side;
		result.edge_stop   = e_stop;
		result.phase       = phase_n;
		result.running     = active_n;
	end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the bump-and-turn cleaning sequencer.
module tb;

	// Codes outside the package enums
	localparam logic [1:0] CMD_NOOP   = 2'd3;
	localparam logic [1:0] BUMP_NONE  = 2'd0;
	localparam logic [1:0] BUMP_LEFT  = 2'd1;
	localparam logic [1:0] BUMP_RIGHT = 2'd2;
	localparam logic [1:0] BUMP_BOTH  = 2'd3;
	localparam logic [9:0] IR_FRONT   = 10'h0D5;
	localparam int SPIN_SLOTS         = 6;
	localparam int TICKS_PER_SETTING  = 75;
	localparam int SETTINGS_RUN       = 6;
	localparam int CYCLE_LIMIT        = 100000;
	localparam int HOLD_CYCLES        = 80;

	// Expected-result tracker: own copy of settings and strategy state
	class sequencer_scoreboard;
		logic [15:0] rev_pulses = 16'd140;
		logic [15:0] edge_ms    = 16'd3000;
		logic [11:0] tolerance  = 12'd500;
		logic [7:0]  far_ceil   = 8'd180;
		logic [7:0]  near_ceil  = 8'd120;
		logic [7:0]  ramp_inc   = 8'd20;
		logic [7:0]  back_speed = 8'd120;
		logic [7:0]  turn_speed = 8'd100;

		bit                 running      = 1'b0;
		rbcs_pkg::phase_e   mode         = rbcs_pkg::PH_CRUISE;
		logic [7:0]         ramp         = '0;
		logic [31:0]        mark_pulses  = '0;
		logic [31:0]        mark_ms      = '0;
		logic signed [12:0] mark_heading = '0;
		logic [2:0]         spin_slot    = '0;

		rbcs_pkg::out_item_t expected_q[$];
		int errors = 0;

		function void set_reg(rbcs_pkg::cfg_idx_e idx, logic [15:0] val);
			case (idx)
			rbcs_pkg::CFG_REVERSE_PULSES:    rev_pulses = val;
			rbcs_pkg::CFG_EDGE_MIN_MS:       edge_ms    = val;
			rbcs_pkg::CFG_HEADING_TOLERANCE: tolerance  = val[11:0];
			rbcs_pkg::CFG_CRUISE_SPEED:      far_ceil   = val[7:0];
			rbcs_pkg::CFG_NEAR_SPEED:        near_ceil  = val[7:0];
			rbcs_pkg::CFG_RAMP_STEP:         ramp_inc   = val[7:0];
			rbcs_pkg::CFG_REVERSE_SPEED:     back_speed = val[7:0];
			default:                         turn_speed = val[7:0];
			endcase
		endfunction

		// Advance the strategy by one accepted tick and queue its result
		function void note_tick(rbcs_pkg::in_item_t it);
			rbcs_pkg::out_item_t res;
			logic [31:0] moved, waited, spin_ms;
			logic [7:0] ceiling;
			logic [8:0] sum;
			bit cliff;
			int drift;
			res    = '0;
			cliff  = it.cliff_left | it.cliff_middle | it.cliff_right;
			moved  = it.wheel_pulses - mark_pulses;
			waited = it.now_ms - mark_ms;
			case (it.cmd)
			rbcs_pkg::CMD_START: begin
				running = 1'b1;
				mode    = rbcs_pkg::PH_CRUISE;
				mark_ms = '0;
			end
			rbcs_pkg::CMD_STOP: begin
				running       = 1'b0;
				mode          = rbcs_pkg::PH_CRUISE;
				mark_ms       = '0;
				res.edge_stop = 1'b1;
			end
			rbcs_pkg::CMD_STEP: if (running) begin
				case (mode)
				rbcs_pkg::PH_CRUISE: if (it.bump_code != BUMP_NONE || cliff) begin
					// back off; cliffs and double bumps take the spin path
					res.set_speed   = 1'b1;
					res.left_speed  = -9'(back_speed);
					res.right_speed = -9'(back_speed);
					mark_pulses     = it.wheel_pulses;
					ramp            = '0;
					if (it.bump_code == BUMP_BOTH || cliff)
						mode = rbcs_pkg::PH_REV_SPIN;
					else if (it.bump_code == BUMP_RIGHT)
						mode = rbcs_pkg::PH_REV_RIGHT;
					else
						mode = rbcs_pkg::PH_REV_LEFT;
				end else begin
					ceiling = ((it.ir_obstacles & IR_FRONT) != '0) ? near_ceil : far_ceil;
					if (ramp < ceiling) begin
						sum  = 9'(ramp) + 9'(ramp_inc);
						ramp = sum[8] ? 8'hFF : sum[7:0];
					end
					res.set_speed   = 1'b1;
					res.left_speed  = 9'(ramp);
					res.right_speed = 9'(ramp);
				end
				rbcs_pkg::PH_REV_SPIN, rbcs_pkg::PH_REV_RIGHT, rbcs_pkg::PH_REV_LEFT:
				if (moved >= 32'(rev_pulses)) begin
					mark_heading = it.heading;
					mark_ms      = it.now_ms;
					if (mode == rbcs_pkg::PH_REV_SPIN) begin
						res.set_speed = 1'b1;
						if (it.now_ms[0] == 1'b0) begin
							res.left_speed  = -9'(turn_speed);
							res.right_speed = 9'(turn_speed);
						end else begin
							res.left_speed  = 9'(turn_speed);
							res.right_speed = -9'(turn_speed);
						end
						mode = rbcs_pkg::PH_SPIN;
					end else begin
						res.edge_start = 1'b1;
						res.edge_side  = (mode == rbcs_pkg::PH_REV_LEFT);
						mode = (mode == rbcs_pkg::PH_REV_LEFT)
							? rbcs_pkg::PH_FOLLOW_LEFT : rbcs_pkg::PH_FOLLOW_RIGHT;
					end
				end
				rbcs_pkg::PH_SPIN: begin
					// slot advances before the time check
					spin_slot = 3'((spin_slot + 3'd1) % SPIN_SLOTS);
					case (spin_slot)
					3'd0:    spin_ms = 32'd500;
					3'd1:    spin_ms = 32'd800;
					3'd2:    spin_ms = 32'd1000;
					3'd3:    spin_ms = 32'd1200;
					3'd4:    spin_ms = 32'd1500;
					default: spin_ms = 32'd2000;
					endcase
					if (waited >= spin_ms)
						mode = rbcs_pkg::PH_CRUISE;
				end
				rbcs_pkg::PH_FOLLOW_RIGHT, rbcs_pkg::PH_FOLLOW_LEFT: begin
					drift = int'(mark_heading) - int'(it.heading);
					if (drift < 0)
						drift = -drift;
					if (waited >= 32'(edge_ms) && drift <= int'(tolerance)) begin
						res.edge_stop = 1'b1;
						mode          = rbcs_pkg::PH_CRUISE;
					end
				end
				default: mode = rbcs_pkg::PH_CRUISE;
				endcase
			end
			default: ;
			endcase
			res.phase   = mode;
			res.running = running;
			expected_q.push_back(res);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [rbcs_pkg::OUT_TDATA_W-1:0] bus);
			rbcs_pkg::out_item_t got, want;
			got.set_speed   = bus[0];
			got.left_speed  = bus[9:1];
			got.right_speed = bus[18:10];
			got.edge_start  = bus[19];
			got.edge_side   = bus[20];
			got.edge_stop   = bus[21];
			got.phase       = bus[24:22];
			got.running     = bus[25];
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, expected nothing, got %h",
					$time, bus);
				return;
			end
			want = expected_q.pop_front();
			compare_field("set_speed", want.set_speed, got.set_speed);
			compare_field("left_speed", want.left_speed, got.left_speed);
			compare_field("right_speed", want.right_speed, got.right_speed);
			compare_field("edge_start", want.edge_start, got.edge_start);
			compare_field("edge_side", want.edge_side, got.edge_side);
			compare_field("edge_stop", want.edge_stop, got.edge_stop);
			compare_field("phase", want.phase, got.phase);
			compare_field("running", want.running, got.running);
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic [rbcs_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [rbcs_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic                             cfg_wr_en;
	logic [rbcs_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [rbcs_pkg::CFG_DATA_W-1:0]  cfg_data;

	sequencer_scoreboard sb;
	int          results_seen = 0;
	int unsigned cycles = 0;
	bit          sender_steady = 1'b0;
	logic [31:0] pulse_ctr = '0;
	logic [31:0] ms_ctr = '0;
	int          head_now = 0;

	random_bump_cleaning_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("random_bump_cleaning_sequencer test failed");
			$finish;
		end
	end

	// Offer one tick, with random gaps, until the block takes it
	task automatic send_tick(input rbcs_pkg::in_item_t it);
		while (!sender_steady && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, it.heading, it.now_ms, it.wheel_pulses, it.ir_obstacles,
			it.cliff_right, it.cliff_middle, it.cliff_left, it.bump_code, it.cmd};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_tick(it);
	endtask

	// cliffs is {right, middle, left}
	task automatic drive_tick(input logic [1:0] cmd, input logic [1:0] bump,
			input logic [2:0] cliffs, input logic [9:0] ir, input logic [31:0] pulses,
			input logic [31:0] now, input int heading);
		rbcs_pkg::in_item_t it;
		it.cmd          = cmd;
		it.bump_code    = bump;
		it.cliff_left   = cliffs[0];
		it.cliff_middle = cliffs[1];
		it.cliff_right  = cliffs[2];
		it.ir_obstacles = ir;
		it.wheel_pulses = pulses;
		it.now_ms       = now;
		it.heading      = 13'(heading);
		send_tick(it);
	endtask

	// Random tick around a moving robot; counts is low for ticks the block ignores
	task automatic random_tick(output bit counts);
		rbcs_pkg::in_item_t it;
		int roll;
		it   = '0;
		roll = $urandom_range(0, 99);
		if (!sb.running)
			it.cmd = (roll < 80) ? rbcs_pkg::CMD_START : (roll < 88) ? CMD_NOOP :
				(roll < 94) ? rbcs_pkg::CMD_STEP : rbcs_pkg::CMD_STOP;
		else
			it.cmd = (roll < 2) ? rbcs_pkg::CMD_STOP : (roll < 4) ? CMD_NOOP :
				(roll < 5) ? rbcs_pkg::CMD_START : rbcs_pkg::CMD_STEP;
		it.bump_code    = ($urandom_range(0, 99) < 10) ? 2'($urandom_range(1, 3)) : BUMP_NONE;
		it.cliff_left   = ($urandom_range(0, 99) < 3);
		it.cliff_middle = ($urandom_range(0, 99) < 3);
		it.cliff_right  = ($urandom_range(0, 99) < 3);
		it.ir_obstacles = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
		// odometry and clock move forward, with rare jumps anywhere
		if ($urandom_range(0, 49) == 0)
			pulse_ctr = $urandom();
		else
			pulse_ctr += $urandom_range(0, int'(sb.rev_pulses) / 3 + 60);
		if ($urandom_range(0, 49) == 0)
			ms_ctr = $urandom();
		else
			ms_ctr += $urandom_range(0, int'(sb.edge_ms) / 5 + 500);
		// heading: mostly still or drifting, sometimes anywhere
		roll = $urandom_range(0, 99);
		if (roll < 10)
			head_now = int'($urandom_range(0, 7200)) - 3600;
		else if (roll < 60)
			head_now += int'($urandom_range(0, 400)) - 200;
		if (head_now > 3600)
			head_now = 3600;
		if (head_now < -3600)
			head_now = -3600;
		it.wheel_pulses = pulse_ctr;
		it.now_ms       = ms_ctr;
		it.heading      = 13'(head_now);
		counts = !(it.cmd == CMD_NOOP || (it.cmd == rbcs_pkg::CMD_STEP && !sb.running));
		send_tick(it);
	endtask

	// Stop offering and wait until every expected result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input rbcs_pkg::cfg_idx_e idx, input logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_setting(input rbcs_pkg::cfg_t c);
		write_reg(rbcs_pkg::CFG_REVERSE_PULSES, c.reverse_pulses);
		write_reg(rbcs_pkg::CFG_EDGE_MIN_MS, c.edge_min_ms);
		write_reg(rbcs_pkg::CFG_HEADING_TOLERANCE, 16'(c.heading_tolerance));
		write_reg(rbcs_pkg::CFG_CRUISE_SPEED, 16'(c.cruise_speed));
		write_reg(rbcs_pkg::CFG_NEAR_SPEED, 16'(c.near_speed));
		write_reg(rbcs_pkg::CFG_RAMP_STEP, 16'(c.ramp_step));
		write_reg(rbcs_pkg::CFG_REVERSE_SPEED, 16'(c.reverse_speed));
		write_reg(rbcs_pkg::CFG_SPIN_SPEED, 16'(c.spin_speed));
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: random stalls, two long hold-offs, one stretch always ready
	initial begin : result_sink
		int hold_left;
		int next_hold_at;
		hold_left    = 0;
		next_hold_at = 120;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (results_seen >= next_hold_at) begin
				hold_left = HOLD_CYCLES;
				next_hold_at += 260;
				m_tready <= 1'b0;
			end else if (results_seen >= 200 && results_seen < 280) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 7);
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		rbcs_pkg::cfg_t setting;
		bit counts;
		int counted;
		sb = new;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default settings
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd0, 32'd0, 0);
		drive_tick(CMD_NOOP, BUMP_BOTH, 3'b111, 10'h3FF, 32'd5, 32'd5, 0);
		drive_tick(rbcs_pkg::CMD_START, BUMP_NONE, 3'b000, 10'h000, 32'd0, 32'd0, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd0, 32'd100, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h001, 32'd0, 32'd200, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h3FF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 3600);
		// one-sided bump, follow left, time and heading windows
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_LEFT, 3'b000, 10'h000, 32'd1000, 32'd9000, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd1100, 32'd9500, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd1140, 32'd10000, 100);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd1200, 32'd12999, 100);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd1200, 32'd13000, 700);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd1200, 32'd13000, -400);
		// right bump with pulse and time counters wrapping
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_RIGHT, 3'b000, 10'h000, 32'hFFFF_FFF0,
			32'd14000, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'h0000_007C,
			32'hFFFF_FF00, -3600);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd200,
			32'h0000_0BB8, -3600);
		// double bump, spin on odd time through the table
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_BOTH, 3'b000, 10'h000, 32'd5000, 32'd19000, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd5140, 32'd20001, 3600);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd5140, 32'd20400, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd5140, 32'd21000, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b000, 10'h000, 32'd5140, 32'd21300, 0);
		// middle cliff, spin on even time, stop mid-spin
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_NONE, 3'b010, 10'h000, 32'd6000, 32'd29000, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_LEFT, 3'b100, 10'h000, 32'd6140, 32'd30000, 0);
		drive_tick(rbcs_pkg::CMD_STOP, BUMP_NONE, 3'b000, 10'h000, 32'd6140, 32'd30100, 0);
		// cliff wins over a one-sided bump
		drive_tick(rbcs_pkg::CMD_START, BUMP_NONE, 3'b000, 10'h000, 32'd6140, 32'd30200, 0);
		drive_tick(rbcs_pkg::CMD_STEP, BUMP_LEFT, 3'b001, 10'h000, 32'd6200, 32'd30300, 0);

		// Random phases under different settings
		for (int s = 0; s < SETTINGS_RUN; s++) begin
			drain();
			case (s)
			0: setting = '0;
			1: setting = '{16'hFFFF, 16'hFFFF, 12'd3600, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
			// ramp overshoots the near ceiling and saturates under the far one
			2: setting = '{16'd140, 16'd500, 12'd3600, 8'd250, 8'd30, 8'd100, 8'd1, 8'd254};
			default: begin
				setting.reverse_pulses    = 16'($urandom_range(0, 600));
				setting.edge_min_ms       = 16'($urandom_range(0, 5000));
				setting.heading_tolerance = 12'($urandom_range(0, 3600));
				setting.cruise_speed      = 8'($urandom_range(0, 255));
				setting.near_speed        = 8'($urandom_range(0, 255));
				setting.ramp_step         = 8'($urandom_range(0, 255));
				setting.reverse_speed     = 8'($urandom_range(0, 255));
				setting.spin_speed        = 8'($urandom_range(0, 255));
			end
			endcase
			apply_setting(setting);
			sender_steady = (s == 2);
			counted = 0;
			while (counted < TICKS_PER_SETTING) begin
				random_tick(counts);
				if (counts)
					counted++;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("random_bump_cleaning_sequencer test passed");
		else
			$display("random_bump_cleaning_sequencer test failed");
		$finish;
	end

endmodule
